@@ sv/twsu_pkg.sv @@
// twsu_pkg: shared types, sizes and codes of the timing wheel scheduler
// used by twsu_ctrl, twsu_dpath and timing_wheel_scheduler_unit; no dependencies
package twsu_pkg;

	localparam int SLOTS        = 256;
	localparam int RES_MS       = 8;
	localparam int ENTRIES      = 64;
	localparam int PAYLOAD_BITS = 32;

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int RES_SH  = $clog2(RES_MS);
	localparam int SPAN_SH = SLOT_W + RES_SH;
	localparam int ENT_W   = $clog2(ENTRIES);
	localparam int LINK_W  = ENT_W + 1;
	localparam int GUARD_W = $clog2(ENTRIES + 2);
	localparam int QUIET_W = $clog2(SLOTS + 1);
	localparam int TIME_W  = 48;
	localparam int TICK_W  = TIME_W + 1;
	localparam int DELAY_W = 32;
	localparam int CNT_W   = 6;
	localparam int HDL_W   = 6;

	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ENTRIES);
	localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0]  MAXP_RESET = 6'd63;

	localparam int PADDR_W = 3;
	localparam logic REG_MAXP = 1'b0;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_IGNORE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ADDED   = 2'd0,
		ST_EXPIRED = 2'd1,
		ST_FULL    = 2'd2,
		ST_DONE    = 2'd3
	} res_status_t;

	typedef struct packed {
		cmd_t                      command;
		logic [TIME_W-1:0]         now_ms;
		logic [DELAY_W-1:0]        delay_ms;
		logic [PAYLOAD_BITS-1:0]   payload;
		logic                      repeat_req;
	} request_t;

	typedef struct packed {
		res_status_t       status;
		logic [HDL_W-1:0]  handle;
		logic [31:0]       expired_payload;
		logic [CNT_W-1:0]  reported_count;
		logic              last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD_CALC,
		S_ADD_RD,
		S_ADD_WR,
		S_ADV_SLOT,
		S_ADV_HEAD,
		S_ADV_NODE,
		S_ADV_EVAL,
		S_RL_CALC,
		S_RL_RD,
		S_RL_WR,
		S_ADV_STEP,
		S_ADV_SKIP,
		S_ADV_JUMP,
		S_ADV_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_req;
		logic start_clr;
		logic emit_full;
		logic add_calc;
		logic head_rd_exp;
		logic link_node;
		logic emit_added;
		logic adv_init;
		logic head_rd_tick;
		logic head_load;
		logic node_rd;
		logic eval;
		logic rl_calc;
		logic relink_done;
		logic step;
		logic skip;
		logic jump;
		logic finish;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		cmd_t command;
		logic free_found;
		logic tick_le_now;
		logic below_limit;
		logic node_valid;
		logic guard_ok;
		logic expired;
		logic repeat_set;
	} sts_t;

endpackage

@@ sv/twsu_ctrl.sv @@
// twsu_ctrl: sequencer of the timing wheel scheduler
// depends on twsu_pkg; drives twsu_dpath through ctl_t and reads sts_t
module twsu_ctrl import twsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		busy     = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load_req = 1'b1;
					state_nx     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.command)
					CMD_START: begin
						ctl.start_clr = 1'b1;
						state_nx      = S_IDLE;
					end
					CMD_ADD: begin
						if (sts.free_found) begin
							ctl.add_calc = 1'b1;
							state_nx     = S_ADD_RD;
						end else begin
							ctl.emit_full = 1'b1;
							state_nx      = S_IDLE;
						end
					end
					CMD_ADVANCE: begin
						ctl.adv_init = 1'b1;
						state_nx     = S_ADV_SLOT;
					end
					default: state_nx = S_IDLE;
				endcase
			end
			S_ADD_CALC: state_nx = S_ADD_RD;
			S_ADD_RD: begin
				ctl.head_rd_exp = 1'b1;
				state_nx        = S_ADD_WR;
			end
			S_ADD_WR: begin
				ctl.link_node  = 1'b1;
				ctl.emit_added = 1'b1;
				state_nx       = S_IDLE;
			end
			S_ADV_SLOT: begin
				if (sts.tick_le_now && sts.below_limit) begin
					ctl.head_rd_tick = 1'b1;
					state_nx         = S_ADV_HEAD;
				end else begin
					state_nx = S_ADV_DONE;
				end
			end
			S_ADV_HEAD: begin
				ctl.head_load = 1'b1;
				state_nx      = S_ADV_NODE;
			end
			S_ADV_NODE: begin
				if (sts.node_valid && sts.below_limit && sts.guard_ok) begin
					ctl.node_rd = 1'b1;
					state_nx    = S_ADV_EVAL;
				end else if (sts.node_valid && sts.guard_ok) begin
					// limit hit inside the bucket: tick stays here
					state_nx = S_ADV_DONE;
				end else begin
					state_nx = S_ADV_STEP;
				end
			end
			S_ADV_EVAL: begin
				ctl.eval = 1'b1;
				if (sts.expired && sts.repeat_set) begin
					state_nx = S_RL_CALC;
				end else begin
					state_nx = S_ADV_NODE;
				end
			end
			S_RL_CALC: begin
				ctl.rl_calc = 1'b1;
				state_nx    = S_RL_RD;
			end
			S_RL_RD: begin
				ctl.head_rd_exp = 1'b1;
				state_nx        = S_RL_WR;
			end
			S_RL_WR: begin
				ctl.link_node   = 1'b1;
				ctl.relink_done = 1'b1;
				state_nx        = S_ADV_NODE;
			end
			S_ADV_STEP: begin
				ctl.step = 1'b1;
				state_nx = S_ADV_SKIP;
			end
			S_ADV_SKIP: begin
				ctl.skip = 1'b1;
				state_nx = S_ADV_JUMP;
			end
			S_ADV_JUMP: begin
				ctl.jump = 1'b1;
				state_nx = S_ADV_SLOT;
			end
			S_ADV_DONE: begin
				ctl.finish = 1'b1;
				state_nx   = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

@@ sv/twsu_dpath.sv @@
// twsu_dpath: wheel tick, bucket heads, entry pool and result register
// depends on twsu_pkg; commanded by twsu_ctrl
module twsu_dpath import twsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  request_t         request,
	input  logic [CNT_W-1:0] max_per_advance,
	output sts_t             sts,
	output logic             result_valid,
	output result_t          result
);

	// bucket heads and entry stores
	logic [LINK_W-1:0]       head_mem [SLOTS];
	logic [SLOTS-1:0]        head_vld_q;
	logic [TIME_W-1:0]       exp_mem  [ENTRIES];
	logic [PAYLOAD_BITS-1:0] pay_mem  [ENTRIES];
	logic [DELAY_W-1:0]      int_mem  [ENTRIES];
	logic                    rep_mem  [ENTRIES];
	logic [LINK_W-1:0]       link_mem [ENTRIES];
	logic [ENTRIES-1:0]      in_use_q;

	logic [LINK_W-1:0]       head_rd_q;
	logic [TIME_W-1:0]       exp_rd_q;
	logic [PAYLOAD_BITS-1:0] pay_rd_q;
	logic [DELAY_W-1:0]      int_rd_q;
	logic                    rep_rd_q;
	logic [LINK_W-1:0]       link_rd_q;

	request_t          req_q;
	logic [TIME_W-1:0] wheel_tick_q;
	logic [TICK_W-1:0] t_q;
	logic [TIME_W-1:0] gap_q;
	logic [TIME_W-1:0] exp_q;
	logic [SLOT_W-1:0] s_q;
	logic [LINK_W-1:0] node_q, prev_q, nxt_q;
	logic [GUARD_W-1:0] guard_q;
	logic [CNT_W-1:0]  count_q;
	logic [QUIET_W-1:0] quiet_q;
	logic              emitted_q;
	logic              rv_q;
	result_t           res_q;
	result_t           res_d;

	logic [ENT_W-1:0]  free_idx;
	logic              free_found;
	logic [ENT_W-1:0]  node_idx;
	logic [SLOT_W-1:0] tick_slot, exp_slot, head_raddr;
	logic              expired;
	logic              head_we;
	logic [SLOT_W-1:0] head_waddr;
	logic [LINK_W-1:0] head_wdata;
	logic              link_we;
	logic [ENT_W-1:0]  link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic [TIME_W:0]   sum_add, sum_rl;

	// lowest free entry
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx   = ENT_W'(i);
				free_found = 1'b1;
			end
		end
	end

	assign node_idx   = node_q[ENT_W-1:0];
	assign tick_slot  = t_q[RES_SH +: SLOT_W];
	assign exp_slot   = exp_q[RES_SH +: SLOT_W];
	assign head_raddr = ctl.head_rd_exp ? exp_slot : tick_slot;
	assign expired    = (exp_rd_q <= req_q.now_ms);
	assign sum_add    = {1'b0, req_q.now_ms} + (TIME_W + 1)'(req_q.delay_ms);
	assign sum_rl     = {1'b0, req_q.now_ms} + (TIME_W + 1)'(int_rd_q);

	assign sts.command     = req_q.command;
	assign sts.free_found  = free_found;
	assign sts.tick_le_now = (t_q <= {1'b0, req_q.now_ms});
	assign sts.below_limit = (count_q < max_per_advance);
	assign sts.node_valid  = (node_q < LINK_NONE);
	assign sts.guard_ok    = (guard_q <= GUARD_W'(ENTRIES));
	assign sts.expired     = expired;
	assign sts.repeat_set  = rep_rd_q;

	// single write port per store, muxed by phase
	always_comb begin
		head_we    = 1'b0;
		head_waddr = exp_slot;
		head_wdata = node_q;
		link_we    = 1'b0;
		link_waddr = node_idx;
		link_wdata = head_rd_q;
		if (ctl.link_node) begin
			head_we = 1'b1;
			link_we = 1'b1;
		end else if (ctl.eval && expired) begin
			// unlink from the bucket being walked
			if (prev_q == LINK_NONE) begin
				head_we    = 1'b1;
				head_waddr = s_q;
				head_wdata = link_rd_q;
			end else begin
				link_we    = 1'b1;
				link_waddr = prev_q[ENT_W-1:0];
				link_wdata = link_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_vld_q[head_raddr] ? head_mem[head_raddr] : LINK_NONE;
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd_q <= link_mem[node_idx];
	end

	always_ff @(posedge clk) begin
		if (ctl.link_node) begin
			exp_mem[node_idx] <= exp_q;
		end
		exp_rd_q <= exp_mem[node_idx];
	end

	always_ff @(posedge clk) begin
		if (ctl.add_calc) begin
			pay_mem[free_idx] <= req_q.payload;
			int_mem[free_idx] <= req_q.delay_ms;
			rep_mem[free_idx] <= req_q.repeat_req;
		end
		pay_rd_q <= pay_mem[node_idx];
		int_rd_q <= int_mem[node_idx];
		rep_rd_q <= rep_mem[node_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q   <= '0;
			in_use_q     <= '0;
			wheel_tick_q <= '0;
			rv_q         <= 1'b0;
		end else begin
			rv_q <= ctl.start_clr | ctl.emit_full | ctl.emit_added | ctl.finish |
				(ctl.eval & expired);
			if (ctl.start_clr) begin
				head_vld_q   <= '0;
				in_use_q     <= '0;
				wheel_tick_q <= req_q.now_ms;
			end
			if (head_we) begin
				head_vld_q[head_waddr] <= 1'b1;
			end
			if (ctl.add_calc) begin
				in_use_q[free_idx] <= 1'b1;
			end
			if (ctl.eval && expired && !rep_rd_q) begin
				in_use_q[node_idx] <= 1'b0;
			end
			if (ctl.finish) begin
				wheel_tick_q <= t_q[TIME_W] ? TIME_MAX : t_q[TIME_W-1:0];
			end
		end
	end

	// next result word
	always_comb begin
		res_d = '0;
		if (ctl.start_clr) begin
			res_d.status = ST_DONE;
			res_d.last   = 1'b1;
		end
		if (ctl.emit_full) begin
			res_d.status = ST_FULL;
			res_d.last   = 1'b1;
		end
		if (ctl.emit_added) begin
			res_d.status = ST_ADDED;
			res_d.handle = HDL_W'(node_idx);
			res_d.last   = 1'b1;
		end
		if (ctl.eval && expired) begin
			res_d.status          = ST_EXPIRED;
			res_d.handle          = HDL_W'(node_idx);
			res_d.expired_payload = 32'(pay_rd_q);
		end
		if (ctl.finish) begin
			res_d.status         = ST_DONE;
			res_d.reported_count = count_q;
			res_d.last           = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			req_q <= request;
		end
		if (ctl.add_calc) begin
			node_q <= {1'b0, free_idx};
			exp_q  <= sum_add[TIME_W] ? TIME_MAX : sum_add[TIME_W-1:0];
		end
		if (ctl.rl_calc) begin
			exp_q <= sum_rl[TIME_W] ? TIME_MAX : sum_rl[TIME_W-1:0];
		end
		if (ctl.adv_init) begin
			t_q     <= {1'b0, wheel_tick_q};
			count_q <= '0;
			quiet_q <= '0;
		end
		if (ctl.head_rd_tick) begin
			s_q <= tick_slot;
		end
		if (ctl.head_load) begin
			node_q    <= head_rd_q;
			prev_q    <= LINK_NONE;
			guard_q   <= '0;
			emitted_q <= 1'b0;
		end
		if (ctl.node_rd) begin
			guard_q <= guard_q + 1'b1;
		end
		if (ctl.eval) begin
			nxt_q <= link_rd_q;
			if (expired) begin
				count_q   <= count_q + 1'b1;
				emitted_q <= 1'b1;
				if (!rep_rd_q) begin
					node_q <= link_rd_q;
				end
			end else begin
				prev_q <= node_q;
				node_q <= link_rd_q;
			end
		end
		if (ctl.relink_done) begin
			if (exp_slot == s_q && prev_q == LINK_NONE) begin
				prev_q <= node_q;
			end
			node_q <= nxt_q;
		end
		if (ctl.step) begin
			t_q     <= t_q + TICK_W'(RES_MS);
			quiet_q <= emitted_q ? '0 : quiet_q + 1'b1;
		end
		if (ctl.skip) begin
			// a silent round: pass over whole rounds at once
			if (quiet_q >= QUIET_W'(SLOTS) && t_q <= {1'b0, req_q.now_ms}) begin
				gap_q   <= (req_q.now_ms - t_q[TIME_W-1:0]) >> SPAN_SH << SPAN_SH;
				quiet_q <= '0;
			end else begin
				gap_q <= '0;
			end
		end
		if (ctl.jump) begin
			t_q <= t_q + {1'b0, gap_q};
		end
		res_q <= res_d;
	end

	assign result_valid = rv_q;
	assign result       = res_q;

endmodule

@@ sv/timing_wheel_scheduler_unit.sv @@
// timing_wheel_scheduler_unit: top level with the register port
// depends on twsu_pkg, twsu_ctrl and twsu_dpath
//
// Hashed timing wheel of 256 buckets of 8 ms over a pool of 64 timers. A request is taken
// when start is high and busy is low; results come one per cycle-wide result_valid pulse
// and cannot be held off, so the receiver must take each one as it appears. Advance visits
// the buckets one by one and looks at each chained timer, relinking repeating timers as
// it goes, by a walk through the bucket chains, one entry store read at a time;
// a round of 256 silent buckets is followed by a jump over all further silent rounds.
module timing_wheel_scheduler_unit import twsu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  request_t           request,
	output logic               result_valid,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [CNT_W-1:0] maxp_q;
	ctl_t             ctl;
	sts_t             sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxp_q <= MAXP_RESET;
		end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_MAXP) begin
			maxp_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_MAXP) begin
			prdata = {{(32 - CNT_W){1'b0}}, maxp_q};
		end
	end

	twsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	twsu_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.request         (request),
		.max_per_advance (maxp_q),
		.sts             (sts),
		.result_valid    (result_valid),
		.result          (result)
	);

endmodule

@@ dv/twsu_checker.sv @@
// twsu_checker: watches the request, result and register channels of the wheel scheduler,
// predicts every result in order and compares; depends on twsu_pkg
`timescale 1ns / 1ps
module twsu_checker import twsu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  request_t           request,
	input  logic               result_valid,
	input  result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending,
	output int                 expiries_seen,
	output int                 full_seen
);

	localparam logic [63:0] SAT48 = 64'hFFFF_FFFF_FFFF;
	localparam int NIL = ENTRIES;

	int          bucket_head_q[SLOTS];
	logic [63:0] ent_expiry[ENTRIES];
	logic [31:0] ent_payload[ENTRIES];
	logic [31:0] ent_interval[ENTRIES];
	bit          ent_repeat[ENTRIES];
	int          ent_next[ENTRIES];
	bit          ent_busy[ENTRIES];
	logic [63:0] tick_q;
	logic [5:0]  limit_q;
	result_t     expected_results[$];

	assign pending = expected_results.size();

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > SAT48) ? SAT48 : s;
	endfunction

	function automatic int bucket_of(logic [63:0] t);
		return int'((t >> RES_SH) % SLOTS);
	endfunction

	task automatic push_result(res_status_t st, int h, logic [31:0] p, int cnt, bit lst);
		result_t r;
		r.status          = st;
		r.handle          = HDL_W'(h);
		r.expired_payload = p;
		r.reported_count  = CNT_W'(cnt);
		r.last            = lst;
		expected_results.push_back(r);
	endtask

	task automatic empty_wheel();
		for (int i = 0; i < SLOTS; i++) bucket_head_q[i] = NIL;
		for (int i = 0; i < ENTRIES; i++) begin
			ent_busy[i] = 1'b0;
			ent_next[i] = NIL;
		end
	endtask

	task automatic link_timer(int e, logic [63:0] ex);
		int s;
		s = bucket_of(ex);
		ent_expiry[e] = ex;
		ent_next[e] = bucket_head_q[s];
		bucket_head_q[s] = e;
	endtask

	task automatic predict_request(request_t rq);
		logic [63:0] now, t, ex, span;
		int e, cnt, quiet, s, prev, node, nxt, guard;
		bit emitted;
		now = {16'd0, rq.now_ms};
		case (rq.command)
			CMD_START: begin
				empty_wheel();
				tick_q = now;
				push_result(ST_DONE, 0, 0, 0, 1);
			end
			CMD_ADD: begin
				e = 0;
				while (e < ENTRIES && ent_busy[e]) e++;
				if (e >= ENTRIES) begin
					push_result(ST_FULL, 0, 0, 0, 1);
				end else begin
					ent_busy[e] = 1'b1;
					ent_payload[e] = rq.payload;
					ent_interval[e] = rq.delay_ms;
					ent_repeat[e] = rq.repeat_req;
					link_timer(e, sat_sum(now, {32'd0, rq.delay_ms}));
					push_result(ST_ADDED, e, 0, 0, 1);
				end
			end
			CMD_ADVANCE: begin
				t = tick_q;
				cnt = 0;
				quiet = 0;
				span = 64'(SLOTS * RES_MS);
				while (t <= now && cnt < limit_q) begin
					s = bucket_of(t);
					prev = NIL;
					node = bucket_head_q[s];
					guard = 0;
					emitted = 1'b0;
					while (node < ENTRIES && cnt < limit_q && guard <= ENTRIES) begin
						nxt = ent_next[node];
						guard++;
						if (ent_expiry[node] <= now) begin
							push_result(ST_EXPIRED, node, ent_payload[node], 0, 0);
							cnt++;
							emitted = 1'b1;
							if (prev == NIL) bucket_head_q[s] = nxt;
							else ent_next[prev] = nxt;
							if (ent_repeat[node]) begin
								ex = sat_sum(now, {32'd0, ent_interval[node]});
								link_timer(node, ex);
								// if relinked at the head of the bucket being walked
								if (bucket_of(ex) == s && prev == NIL) prev = node;
							end else begin
								ent_busy[node] = 1'b0;
							end
						end else begin
							prev = node;
						end
						node = nxt;
					end
					if (node < ENTRIES && guard <= ENTRIES) break;
					t += 64'(RES_MS);
					quiet = emitted ? 0 : quiet + 1;
					if (quiet >= SLOTS && t <= now) begin
						t += ((now - t) / span) * span;
						quiet = 0;
					end
				end
				tick_q = (t > SAT48) ? SAT48 : t;
				push_result(ST_DONE, 0, 0, cnt, 1);
			end
			default: ;
		endcase
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			empty_wheel();
			tick_q = '0;
			limit_q = MAXP_RESET;
			expected_results.delete();
			errors = 0;
			expiries_seen = 0;
			full_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_MAXP, 2'b00})
				limit_q = pwdata[CNT_W-1:0];
			if (start && !busy)
				predict_request(request);
			if (result_valid) begin
				if (result.status == ST_EXPIRED) expiries_seen++;
				if (result.status == ST_FULL) full_seen++;
				if (expected_results.size() == 0) begin
					report("unexpected result", 64'(result), 64'd0);
				end else begin
					w = expected_results.pop_front();
					if (result.status != w.status)
						report("status", 64'(result.status), 64'(w.status));
					if (result.handle != w.handle)
						report("handle", 64'(result.handle), 64'(w.handle));
					if (result.expired_payload != w.expired_payload)
						report("expired_payload", 64'(result.expired_payload),
							64'(w.expired_payload));
					if (result.reported_count != w.reported_count)
						report("reported_count", 64'(result.reported_count),
							64'(w.reported_count));
					if (result.last != w.last)
						report("last", 64'(result.last), 64'(w.last));
				end
			end
		end
	end

endmodule

@@ dv/tb_top.sv @@
// tb_top: stimulus, register writes, watchdog and verdict for timing_wheel_scheduler_unit
// depends on twsu_pkg, the block and twsu_checker
`timescale 1ns / 1ps
module tb_top;
	import twsu_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

	logic               clk, arst_n, start, busy, result_valid;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata, prdata;
	request_t           request;
	result_t            result;
	int                 errors, pending, expiries_seen, full_seen;
	int                 idle_cycles, requests_sent, idle_pct;
	logic [47:0]        wall_ms;

	timing_wheel_scheduler_unit dut (.*);

	twsu_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	task automatic send(cmd_t c, logic [47:0] now, logic [31:0] dly, logic [31:0] pay, bit rep);
		request_t r;
		r.command = c;
		r.now_ms = now;
		r.delay_ms = dly;
		r.payload = pay;
		r.repeat_req = rep;
		start <= 1'b1;
		request <= r;
		while (busy) @(negedge clk);
		@(negedge clk);
		requests_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(12, 1)) @(negedge clk);
		end
	endtask

	// register writes only once the wheel has drained
	task automatic write_limit(logic [5:0] v);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy) @(negedge clk);
		repeat (10) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_MAXP, 2'b00};
		pwdata <= {26'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_request();
		int k;
		logic [47:0] now;
		logic [31:0] dly;
		k = $urandom_range(99);
		now = wall_ms;
		if ($urandom_range(19) == 0) now = 48'({$urandom, $urandom} & T_MAX);
		dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
		if (k < 4) begin
			wall_ms = 48'($urandom_range(5000));
			send(CMD_START, wall_ms, $urandom, $urandom, 1'($urandom_range(1)));
		end else if (k < 6) begin
			send(CMD_IGNORE, 48'({$urandom, $urandom}), $urandom, $urandom,
				1'($urandom_range(1)));
		end else if (k < 55) begin
			send(CMD_ADD, now, dly, $urandom, $urandom_range(3) == 0);
		end else begin
			wall_ms = wall_ms + 48'($urandom_range(600));
			send(CMD_ADVANCE, ($urandom_range(29) == 0) ? now : wall_ms,
				$urandom, $urandom, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		request = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		requests_sent = 0;
		idle_pct = 0;
		wall_ms = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		fork
			begin
				// directed opening
				send(CMD_START, 48'd0, 0, 0, 0);
				send(CMD_ADD, 48'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
				send(CMD_ADD, 48'd0, 32'hFFFF_FFFF, 32'h0, 1'b1);
				send(CMD_ADD, 48'd5, 32'd0, 32'hA5A5_5A5A, 1'b1);
				send(CMD_ADD, 48'd3, 32'd20, 32'h1234_5678, 1'b1);
				send(CMD_ADD, 48'd1, 32'd40, 32'h5555_AAAA, 1'b0);
				send(CMD_ADVANCE, 48'd100, 0, 0, 0);
				send(CMD_IGNORE, T_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
				write_limit(6'd1);
				send(CMD_ADD, 48'd100, 32'd0, 32'd7, 1'b0);
				send(CMD_ADD, 48'd100, 32'd1, 32'd8, 1'b0);
				send(CMD_ADVANCE, 48'd200, 0, 0, 0);
				send(CMD_ADVANCE, 48'd200, 0, 0, 0);
				write_limit(6'd0);
				send(CMD_ADVANCE, 48'd300, 0, 0, 0);
				write_limit(6'd63);
				send(CMD_ADVANCE, 48'd50, 0, 0, 0);
				send(CMD_ADD, T_MAX - 48'd5, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1);
				send(CMD_ADVANCE, T_MAX, 0, 0, 0);
				send(CMD_ADVANCE, 48'd10, 0, 0, 0);
				send(CMD_START, T_MAX, 0, 0, 0);
				send(CMD_ADVANCE, T_MAX, 0, 0, 0);
				send(CMD_START, 48'd0, 0, 0, 0);
				wall_ms = 0;
				for (int ph = 0; ph < 4; ph++) begin
					write_limit(ph == 0 ? 6'd63 : ph == 1 ? 6'd1 : 6'($urandom_range(63, 2)));
					idle_pct = (ph == 1) ? 49 : (ph == 3) ? 22 : 0;
					for (int i = 0; i < 65; i++) random_request();
				end
				start <= 1'b0;
				while (pending != 0) @(negedge clk);
				repeat (50) @(negedge clk);
				$display("requests sent: %0d, expiries reported: %0d, pool full replies: %0d",
					requests_sent, expiries_seen, full_seen);
				if (errors == 0 && pending == 0) begin
					$display("TB_OK");
				end else begin
					$display("TB_ERROR");
				end
				$finish;
			end
			begin
				idle_cycles = 0;
				while (idle_cycles < STALL_LIMIT) begin
					@(posedge clk);
					if ((start && !busy) || result_valid || psel) idle_cycles = 0;
					else idle_cycles++;
				end
				$display("watchdog expired with %0d results outstanding", pending);
				$display("TB_ERROR");
				$finish;
			end
		join_any
	end

endmodule
